### rtl/variable_width_bit_packer_core_assert.svh
// ----------------------------------------------------------------------------
// variable_width_bit_packer_core_assert.svh
// assertion macros for the bit packer, empty when synthesised
// ----------------------------------------------------------------------------
`ifndef VARIABLE_WIDTH_BIT_PACKER_CORE_ASSERT_SVH
`define VARIABLE_WIDTH_BIT_PACKER_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define VWBP_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define VWBP_ASSERT(lbl, prop, msg) \
  `VWBP_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)
`else
`define VWBP_ASSERT_CLK(lbl, clk, rstn, prop, msg)
`define VWBP_ASSERT(lbl, prop, msg)
`endif

`endif

### rtl/vwbp_pkg.sv
// ----------------------------------------------------------------------------
// vwbp_pkg
// shared widths, codes and types of the variable width bit packer
// ----------------------------------------------------------------------------
`default_nettype none

package vwbp_pkg;

  localparam int unsigned FieldW   = 32;
  localparam int unsigned CountW   = 6;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned PosW     = 4;
  localparam int unsigned AddrW    = 3;
  localparam int unsigned DataW    = 32;

  localparam logic [CountW-1:0] MaxFieldBits = CountW'(FieldW);
  localparam logic [PosW-1:0]   ByteBits     = PosW'(ByteW);

  // register index lives in paddr[2]
  localparam logic RegMsbFirst = 1'b0;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_FLUSH = 1'b1
  } opcode_e;

  // one digit of the field, offered to the byte assembler
  typedef struct packed {
    logic [ByteW-1:0]  bits;
    logic [PosW-1:0]   width;
    logic [CountW-1:0] left;
  } digit_t;

  typedef struct packed {
    logic step;
    logic clear;
  } byte_ctl_t;

  typedef struct packed {
    logic [ByteW-1:0] data;
    logic [PosW-1:0]  room;
    logic             full;
    logic             holds;
  } byte_stat_t;

endpackage

`default_nettype wire

### rtl/vwbp_field_sr.sv
// ----------------------------------------------------------------------------
// vwbp_field_sr
// field shift register: hands the field out one digit of up to eight bits
// ----------------------------------------------------------------------------
`default_nettype none

module vwbp_field_sr
  import vwbp_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              msb_first_i,
  input  logic              load_i,
  input  logic [CountW-1:0] load_count_i,
  input  logic [FieldW-1:0] load_value_i,
  input  logic              step_i,
  input  logic [PosW-1:0]   room_i,
  output digit_t            digit_o
);

  logic [FieldW-1:0] sr_q, sr_d;
  logic [CountW-1:0] left_q, left_d;
  logic [FieldW:0]   ones_sh;
  logic [FieldW-1:0] low_mask;
  logic [CountW-1:0] top_sh;
  logic [PosW-1:0]   now;

  always_comb begin
    ones_sh  = {(FieldW+1){1'b1}} << load_count_i;
    low_mask = ~ones_sh[FieldW-1:0];
    top_sh   = MaxFieldBits - load_count_i;
    if (left_q < CountW'(room_i)) begin
      now = left_q[PosW-1:0];
    end else begin
      now = room_i;
    end
  end

  always_comb begin
    sr_d   = sr_q;
    left_d = left_q;
    if (load_i) begin
      // msb-first keeps the field top-aligned, lsb-first bottom-aligned
      if (msb_first_i) begin
        sr_d = load_value_i << top_sh;
      end else begin
        sr_d = load_value_i & low_mask;
      end
      left_d = load_count_i;
    end else if (step_i) begin
      if (msb_first_i) begin
        sr_d = sr_q << now;
      end else begin
        sr_d = sr_q >> now;
      end
      left_d = left_q - CountW'(now);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q <= '0;
    end else begin
      left_q <= left_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sr_q <= sr_d;
  end

  assign digit_o.bits  = msb_first_i ? sr_q[FieldW-1 -: ByteW] : sr_q[ByteW-1:0];
  assign digit_o.width = now;
  assign digit_o.left  = left_q;

endmodule

`default_nettype wire

### rtl/vwbp_byte_asm.sv
// ----------------------------------------------------------------------------
// vwbp_byte_asm
// byte assembler: merges digits into the one-byte buffer
// ----------------------------------------------------------------------------
`default_nettype none

module vwbp_byte_asm
  import vwbp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       msb_first_i,
  input  byte_ctl_t  ctl_i,
  input  digit_t     digit_i,
  output byte_stat_t stat_o
);

  logic [ByteW-1:0] buf_q, buf_d;
  logic [PosW-1:0]  pos_q, pos_d;
  logic             holds_q, holds_d;
  logic [ByteW-1:0] base_buf;
  logic [PosW-1:0]  base_pos;
  logic [ByteW:0]   low9;
  logic [ByteW-1:0] low_mask, top_mask, mask, chunk;

  always_comb begin
    // a full (or empty) buffer starts a fresh byte
    if (pos_q >= ByteBits) begin
      base_buf = '0;
      base_pos = '0;
    end else begin
      base_buf = buf_q;
      base_pos = pos_q;
    end
    low9     = (9'd1 << digit_i.width) - 9'd1;
    low_mask = low9[ByteW-1:0];
    top_mask = 8'hff << (ByteBits - digit_i.width);
    if (msb_first_i) begin
      mask  = top_mask >> base_pos;
      chunk = (digit_i.bits & top_mask) >> base_pos;
    end else begin
      mask  = low_mask << base_pos;
      chunk = (digit_i.bits & low_mask) << base_pos;
    end
  end

  always_comb begin
    buf_d   = buf_q;
    pos_d   = pos_q;
    holds_d = holds_q;
    if (ctl_i.clear) begin
      buf_d   = '0;
      pos_d   = ByteBits;
      holds_d = 1'b0;
    end else if (ctl_i.step) begin
      buf_d   = (base_buf & ~mask) | chunk;
      pos_d   = base_pos + digit_i.width;
      holds_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_q   <= '0;
      pos_q   <= ByteBits;
      holds_q <= 1'b0;
    end else begin
      buf_q   <= buf_d;
      pos_q   <= pos_d;
      holds_q <= holds_d;
    end
  end

  assign stat_o.data  = buf_q;
  assign stat_o.room  = ByteBits - base_pos;
  assign stat_o.full  = (pos_q >= ByteBits) && holds_q;
  assign stat_o.holds = holds_q;

endmodule

`default_nettype wire

### rtl/variable_width_bit_packer_core.sv
// ----------------------------------------------------------------------------
// variable_width_bit_packer_core
// packs fields of 0 to 32 bits into a byte stream, lsb-first or msb-first
// ----------------------------------------------------------------------------
//  channel  direction  handshake                  payload
//  in       slave      in_valid_i / in_stall_o    opcode, bit_count, field_value
//  out      master     out_valid_o / out_stall_i  out_byte, last_of_run
//  apb      slave      psel/penable/pready        msb_first at byte address 0
//
//  a write hands the field on in digits of up to eight bits, the digit cut at
//  byte boundaries. reset empties the byte buffer; no clearing pass is needed.
//  a full output register stalls only emitting steps; input is taken when idle.
// ----------------------------------------------------------------------------
`default_nettype none

`include "variable_width_bit_packer_core_assert.svh"

module variable_width_bit_packer_core
  import vwbp_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [0:0]        opcode_i,
  input  logic [CountW-1:0] bit_count_i,
  input  logic [FieldW-1:0] field_value_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [ByteW-1:0]  out_byte_o,
  output logic              last_of_run_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [AddrW-1:0]  paddr,
  input  logic [DataW-1:0]  pwdata,
  output logic [DataW-1:0]  prdata,
  output logic              pready
);

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StWrite = 2'd1;
  localparam logic [1:0] StFlush = 2'd2;

  logic [1:0]        state_q, state_d;
  logic              msb_first_q;
  logic              out_valid_q, out_valid_d;
  logic [ByteW-1:0]  out_byte_q;
  logic              last_q;
  logic              in_xfer, out_free;
  logic [CountW-1:0] count_sat;
  logic              load;
  logic              emit, emit_last;
  byte_ctl_t         ctl;
  byte_stat_t        stat;
  digit_t            digit;

  // configuration
  assign pready = 1'b1;
  assign prdata = (paddr[2] == RegMsbFirst) ? DataW'(msb_first_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      msb_first_q <= 1'b0;
    end else if (psel && penable && pwrite && pready && paddr[2] == RegMsbFirst) begin
      msb_first_q <= pwdata[0];
    end
  end

  // input transfer
  assign in_stall_o = (state_q != StIdle);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign count_sat  = (bit_count_i > MaxFieldBits) ? MaxFieldBits : bit_count_i;
  assign load       = in_xfer && (opcode_i == OP_WRITE) && (count_sat != '0);
  assign out_free   = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d   = state_q;
    ctl.step  = 1'b0;
    ctl.clear = 1'b0;
    emit      = 1'b0;
    emit_last = 1'b0;
    case (state_q)
      StIdle: begin
        if (in_xfer) begin
          if (opcode_i == OP_FLUSH) begin
            state_d = StFlush;
          end else if (count_sat != '0) begin
            state_d = StWrite;
          end
        end
      end
      StWrite: begin
        // starting a new byte releases the held one
        if (!stat.full || out_free) begin
          ctl.step  = 1'b1;
          emit      = stat.full;
          emit_last = (digit.left <= CountW'(ByteW));
          if (digit.left == CountW'(digit.width)) begin
            state_d = StIdle;
          end
        end
      end
      StFlush: begin
        if (!stat.holds || out_free) begin
          ctl.clear = 1'b1;
          emit      = stat.holds;
          emit_last = 1'b1;
          state_d   = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  vwbp_field_sr u_field_sr (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .msb_first_i  (msb_first_q),
    .load_i       (load),
    .load_count_i (count_sat),
    .load_value_i (field_value_i),
    .step_i       (ctl.step),
    .room_i       (stat.room),
    .digit_o      (digit)
  );

  vwbp_byte_asm u_byte_asm (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .msb_first_i (msb_first_q),
    .ctl_i       (ctl),
    .digit_i     (digit),
    .stat_o      (stat)
  );

  // output register
  assign out_valid_d = out_free ? emit : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && emit) begin
      out_byte_q <= stat.data;
      last_q     <= emit_last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_byte_o    = out_byte_q;
  assign last_of_run_o = last_q;

  `VWBP_ASSERT(a_emit_busy, $rose(out_valid_q) |-> $past(state_q != StIdle), "emit while idle")
  `VWBP_ASSERT(a_room_range, (stat.room != '0) && (stat.room <= ByteBits), "room out of range")
  `VWBP_ASSERT(a_write_bits, (state_q == StWrite) |-> (digit.left != '0), "write with no bits")
  `VWBP_ASSERT(a_flush_empty, ctl.clear |=> !stat.holds, "flush left data in the buffer")

endmodule

`default_nettype wire
